// ===== sv/cbf_pkg.sv =====
// shared types, widths, codes and helpers for the circuit breaker block
// no dependencies; used by every module of the block
package cbf_pkg;

    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int PERMIT_W = 32;
    localparam int CFG_W    = 32;
    localparam int IDX_W    = 3;
    localparam int ACT_W    = 2;

    // stream payload widths, rounded up to whole bytes
    localparam int IN_FIELDS_W  = TIME_W + PERMIT_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int IN_USER_W    = ((ACT_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + PERMIT_W + 1 + 2;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic [TIME_W-1:0]   t_time;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [PERMIT_W-1:0] t_permit;
    typedef logic [ACT_W-1:0]    t_action;

    typedef enum logic [1:0] {
        MODE_CLOSED = 2'd0,
        MODE_OPEN   = 2'd1,
        MODE_HALF   = 2'd2
    } t_mode;

    localparam t_action ACT_REQ  = 2'd0;
    localparam t_action ACT_OK   = 2'd1;
    localparam t_action ACT_FAIL = 2'd2;

    localparam logic [IDX_W-1:0] REG_THRESH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_WINDOW  = 3'd1;
    localparam logic [IDX_W-1:0] REG_TIMEOUT = 3'd2;
    localparam logic [IDX_W-1:0] REG_LIMIT   = 3'd3;
    localparam logic [IDX_W-1:0] REG_NEED    = 3'd4;

    localparam t_count RST_THRESH  = 16'd5;
    localparam t_time  RST_WINDOW  = 32'd60000;
    localparam t_time  RST_TIMEOUT = 32'd30000;
    localparam t_count RST_LIMIT   = 16'd1;
    localparam t_count RST_NEED    = 16'd1;

    // effective configuration seen by the core
    typedef struct packed {
        t_count thresh;
        t_time  window;
        t_time  timeout;
        t_count limit;
        t_count need;
    } t_cfg;

    typedef struct packed {
        logic    granted;
        t_permit permit;
        logic    applied;
        t_mode   mode;
    } t_result;

    function automatic t_count sat_inc(input t_count v);
        return (v == {COUNT_W{1'b1}}) ? v : v + t_count'(1);
    endfunction

endpackage

// ===== sv/circuit_breaker_fsm.sv =====
// an accepted input item passes the input register, then the result register
// throughput: one item per cycle while the receiver does not stall the result register;
// the breaker state updates in the same pass as the result register, so each item
// sees the state left by the one before it
// reset: synchronous active-low i_rst_n; mode closed, counters and generation zero,
// configuration back to 5 / 60000 / 30000 / 1 / 1
// top level: stream wrapper around cbf_cfg_regs and cbf_core, depends on cbf_pkg
module circuit_breaker_fsm (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [cbf_pkg::IDX_W-1:0]      i_cfg_idx,
    input  logic [cbf_pkg::CFG_W-1:0]      i_cfg_data,
    // input items
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [cbf_pkg::IN_DATA_W-1:0]  i_s_tdata,   // now_ms, permit_in
    input  logic [cbf_pkg::IN_USER_W-1:0]  i_s_tuser,   // action, zero fill
    // result items
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [cbf_pkg::OUT_DATA_W-1:0] o_m_tdata    // granted, permit_out,
                                                        // report_applied, breaker_mode
);

    localparam int PERMIT_LO = cbf_pkg::TIME_W;
    localparam int PERMIT_HI = cbf_pkg::TIME_W + cbf_pkg::PERMIT_W - 1;

    // input register stage
    logic             r_in_vld;
    cbf_pkg::t_action r_action;
    cbf_pkg::t_time   r_now;
    cbf_pkg::t_permit r_permit;

    // result register stage
    logic             r_out_vld;
    cbf_pkg::t_result r_out;

    cbf_pkg::t_cfg    w_cfg;
    cbf_pkg::t_result w_res;
    logic             w_adv;
    logic             w_take;

    // the held item moves on when the result register is empty or being drained
    assign w_adv      = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || w_adv;
    assign w_take     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_take) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_action <= i_s_tuser[cbf_pkg::ACT_W-1:0];
            r_now    <= i_s_tdata[cbf_pkg::TIME_W-1:0];
            r_permit <= i_s_tdata[PERMIT_HI:PERMIT_LO];
        end
    end

    cbf_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // state commits only when the item really advances
    cbf_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_action (r_action),
        .i_now    (r_now),
        .i_permit (r_permit),
        .i_cfg    (w_cfg),
        .o_res    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(cbf_pkg::OUT_DATA_W - cbf_pkg::OUT_FIELDS_W){1'b0}},
                         r_out.mode, r_out.applied, r_out.permit, r_out.granted};

endmodule

// ===== sv/cbf_cfg_regs.sv =====
// configuration register file with effective-value derivation
// depends on cbf_pkg
module cbf_cfg_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [cbf_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [cbf_pkg::CFG_W-1:0] i_cfg_data,
    output cbf_pkg::t_cfg             o_cfg
);

    cbf_pkg::t_count r_thresh;
    cbf_pkg::t_time  r_window;
    cbf_pkg::t_time  r_timeout;
    cbf_pkg::t_count r_limit;
    cbf_pkg::t_count r_need;

    cbf_pkg::t_count w_limit;
    cbf_pkg::t_count w_need;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh  <= cbf_pkg::RST_THRESH;
            r_window  <= cbf_pkg::RST_WINDOW;
            r_timeout <= cbf_pkg::RST_TIMEOUT;
            r_limit   <= cbf_pkg::RST_LIMIT;
            r_need    <= cbf_pkg::RST_NEED;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cbf_pkg::REG_THRESH:  r_thresh  <= i_cfg_data[cbf_pkg::COUNT_W-1:0];
                cbf_pkg::REG_WINDOW:  r_window  <= i_cfg_data[cbf_pkg::TIME_W-1:0];
                cbf_pkg::REG_TIMEOUT: r_timeout <= i_cfg_data[cbf_pkg::TIME_W-1:0];
                cbf_pkg::REG_LIMIT:   r_limit   <= i_cfg_data[cbf_pkg::COUNT_W-1:0];
                cbf_pkg::REG_NEED:    r_need    <= i_cfg_data[cbf_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one; success count capped at probe limit
    assign w_limit = (r_limit == '0) ? cbf_pkg::t_count'(1) : r_limit;
    assign w_need  = (r_need == '0) ? cbf_pkg::t_count'(1) : r_need;

    always_comb begin
        o_cfg.thresh  = (r_thresh == '0) ? cbf_pkg::t_count'(1) : r_thresh;
        o_cfg.window  = (r_window == '0) ? cbf_pkg::t_time'(1) : r_window;
        o_cfg.timeout = r_timeout;
        o_cfg.limit   = w_limit;
        o_cfg.need    = (w_need > w_limit) ? w_limit : w_need;
    end

endmodule

// ===== sv/cbf_core.sv =====
// breaker state registers and the single-pass update for one item
// depends on cbf_pkg
module cbf_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  cbf_pkg::t_action     i_action,
    input  cbf_pkg::t_time       i_now,
    input  cbf_pkg::t_permit     i_permit,
    input  cbf_pkg::t_cfg        i_cfg,
    output cbf_pkg::t_result     o_res
);

    cbf_pkg::t_mode   r_mode,      n_mode;
    cbf_pkg::t_count  r_count,     n_count;
    cbf_pkg::t_time   r_last_fail, n_last_fail;
    logic             r_seen,      n_seen;
    cbf_pkg::t_time   r_opened,    n_opened;
    cbf_pkg::t_count  r_probes,    n_probes;
    cbf_pkg::t_count  r_succ,      n_succ;
    cbf_pkg::t_permit r_gen,       n_gen;

    cbf_pkg::t_time   w_el_open;
    cbf_pkg::t_time   w_el_fail;
    logic             w_match;
    logic             w_to_half;
    logic             w_probe_ok;
    logic             w_fail_stale;
    cbf_pkg::t_count  w_cnt_new;
    cbf_pkg::t_count  w_succ_new;
    cbf_pkg::t_permit w_gen_inc;

    assign w_el_open    = i_now - r_opened;
    assign w_el_fail    = i_now - r_last_fail;
    assign w_match      = (i_permit == r_gen);
    assign w_gen_inc    = r_gen + cbf_pkg::t_permit'(1);
    assign w_to_half    = (r_mode == cbf_pkg::MODE_OPEN) && (w_el_open >= i_cfg.timeout);
    assign w_probe_ok   = (r_mode == cbf_pkg::MODE_HALF) && (r_probes < i_cfg.limit);
    assign w_fail_stale = r_seen && (w_el_fail >= i_cfg.window);
    assign w_cnt_new    = cbf_pkg::sat_inc(w_fail_stale ? '0 : r_count);
    assign w_succ_new   = cbf_pkg::sat_inc(r_succ);

    // next state
    always_comb begin
        n_mode      = r_mode;
        n_count     = r_count;
        n_last_fail = r_last_fail;
        n_seen      = r_seen;
        n_opened    = r_opened;
        n_probes    = r_probes;
        n_succ      = r_succ;
        n_gen       = r_gen;
        unique case (i_action)
            cbf_pkg::ACT_REQ: begin
                if (w_to_half) begin
                    // turning half-open grants the first probe at once
                    n_mode   = cbf_pkg::MODE_HALF;
                    n_gen    = w_gen_inc;
                    n_probes = cbf_pkg::t_count'(1);
                    n_succ   = '0;
                end else if (w_probe_ok) begin
                    n_probes = cbf_pkg::sat_inc(r_probes);
                end
            end
            cbf_pkg::ACT_OK: begin
                if (w_match && r_mode == cbf_pkg::MODE_CLOSED) begin
                    if (!r_seen || w_el_fail >= i_cfg.window) begin
                        n_count = '0;
                    end
                end else if (w_match && r_mode == cbf_pkg::MODE_HALF) begin
                    n_succ = w_succ_new;
                    if (w_succ_new >= i_cfg.need && w_succ_new == r_probes) begin
                        n_mode      = cbf_pkg::MODE_CLOSED;
                        n_gen       = w_gen_inc;
                        n_count     = '0;
                        n_last_fail = '0;
                        n_seen      = 1'b0;
                        n_opened    = '0;
                        n_probes    = '0;
                        n_succ      = '0;
                    end
                end
            end
            cbf_pkg::ACT_FAIL: begin
                if (w_match && r_mode == cbf_pkg::MODE_HALF) begin
                    n_mode   = cbf_pkg::MODE_OPEN;
                    n_gen    = w_gen_inc;
                    n_opened = i_now;
                    n_probes = '0;
                    n_succ   = '0;
                end else if (w_match && r_mode == cbf_pkg::MODE_CLOSED) begin
                    n_last_fail = i_now;
                    n_seen      = 1'b1;
                    n_count     = w_cnt_new;
                    if (w_cnt_new >= i_cfg.thresh) begin
                        n_mode   = cbf_pkg::MODE_OPEN;
                        n_gen    = w_gen_inc;
                        n_opened = i_now;
                        n_probes = '0;
                        n_succ   = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    // result of the item
    always_comb begin
        o_res.granted = 1'b0;
        o_res.permit  = '0;
        o_res.applied = 1'b0;
        o_res.mode    = n_mode;
        unique case (i_action)
            cbf_pkg::ACT_REQ: begin
                if (r_mode == cbf_pkg::MODE_CLOSED || w_probe_ok) begin
                    o_res.granted = 1'b1;
                    o_res.permit  = r_gen;
                end else if (w_to_half) begin
                    o_res.granted = 1'b1;
                    o_res.permit  = w_gen_inc;
                end
            end
            cbf_pkg::ACT_OK,
            cbf_pkg::ACT_FAIL: o_res.applied = w_match;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= cbf_pkg::MODE_CLOSED;
            r_count     <= '0;
            r_last_fail <= '0;
            r_seen      <= 1'b0;
            r_opened    <= '0;
            r_probes    <= '0;
            r_succ      <= '0;
            r_gen       <= '0;
        end else if (i_en) begin
            r_mode      <= n_mode;
            r_count     <= n_count;
            r_last_fail <= n_last_fail;
            r_seen      <= n_seen;
            r_opened    <= n_opened;
            r_probes    <= n_probes;
            r_succ      <= n_succ;
            r_gen       <= n_gen;
        end
    end

endmodule

// ===== sv/cbf_checker.sv =====
// port-level checks for circuit_breaker_fsm, attached by bind
// depends on cbf_pkg
module cbf_port_checks (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [cbf_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    localparam int P_HI = cbf_pkg::PERMIT_W;
    localparam int A_B  = cbf_pkg::PERMIT_W + 1;
    localparam int M_LO = cbf_pkg::PERMIT_W + 2;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // no result right after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // a refused request carries no permit
    a_permit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> o_m_tdata[P_HI:1] == '0)
        else $error("permit without grant");

    // grant and applied report never in one item
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[A_B]))
        else $error("grant and report in one item");

    // mode code stays within closed, open, half-open
    a_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[M_LO+1:M_LO] != 2'b11)
        else $error("bad mode code");

endmodule

bind circuit_breaker_fsm cbf_port_checks u_cbf_port_checks (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== test/cbf_checker.sv =====
`timescale 1ns / 100ps
// result checker for the circuit breaker: tracks config writes and accepted input
// items, predicts each result item and compares it with the block's output
// depends on cbf_pkg
module cbf_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cbf_pkg::IDX_W-1:0]      i_cfg_idx,
    input  logic [cbf_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [cbf_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic [cbf_pkg::IN_USER_W-1:0]  i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [cbf_pkg::OUT_DATA_W-1:0] i_m_tdata,
    output int                             o_errors,
    output int                             o_waiting,
    output cbf_pkg::t_permit               o_gen_hint
);

    // register copies
    cbf_pkg::t_count cfg_thresh;
    cbf_pkg::t_time  cfg_window;
    cbf_pkg::t_time  cfg_timeout;
    cbf_pkg::t_count cfg_limit;
    cbf_pkg::t_count cfg_need;

    // breaker state copy
    cbf_pkg::t_mode   mode;
    cbf_pkg::t_count  fail_cnt;
    cbf_pkg::t_time   last_fail;
    logic             fail_seen;
    cbf_pkg::t_time   opened_at;
    cbf_pkg::t_count  probes;
    cbf_pkg::t_count  probe_ok;
    cbf_pkg::t_permit gen;

    cbf_pkg::t_result expected_results[$];
    int               errors = 0;

    function automatic cbf_pkg::t_count count_up(input cbf_pkg::t_count v);
        return (&v) ? v : v + cbf_pkg::t_count'(1);
    endfunction

    task automatic clear_breaker();
        cfg_thresh  = cbf_pkg::RST_THRESH;
        cfg_window  = cbf_pkg::RST_WINDOW;
        cfg_timeout = cbf_pkg::RST_TIMEOUT;
        cfg_limit   = cbf_pkg::RST_LIMIT;
        cfg_need    = cbf_pkg::RST_NEED;
        mode        = cbf_pkg::MODE_CLOSED;
        fail_cnt    = '0;
        last_fail   = '0;
        fail_seen   = 1'b0;
        opened_at   = '0;
        probes      = '0;
        probe_ok    = '0;
        gen         = '0;
    endtask

    task automatic trip_open(input cbf_pkg::t_time at_ms);
        opened_at = at_ms;
        probes    = '0;
        probe_ok  = '0;
        mode      = cbf_pkg::MODE_OPEN;
        gen       = gen + cbf_pkg::t_permit'(1);
    endtask

    task automatic breaker_step(input cbf_pkg::t_action act, input cbf_pkg::t_time at_ms,
                                input cbf_pkg::t_permit permit_in,
                                output cbf_pkg::t_result res);
        cbf_pkg::t_count limit;
        cbf_pkg::t_count need;
        cbf_pkg::t_count thresh;
        cbf_pkg::t_time  window;
        limit  = (cfg_limit  == '0) ? cbf_pkg::t_count'(1) : cfg_limit;
        need   = (cfg_need   == '0) ? cbf_pkg::t_count'(1) : cfg_need;
        thresh = (cfg_thresh == '0) ? cbf_pkg::t_count'(1) : cfg_thresh;
        window = (cfg_window == '0) ? cbf_pkg::t_time'(1)  : cfg_window;
        if (need > limit)
            need = limit;
        res = '0;
        unique case (act)
            cbf_pkg::ACT_REQ: begin
                if (mode == cbf_pkg::MODE_CLOSED) begin
                    res.granted = 1'b1;
                    res.permit  = gen;
                end else begin
                    if (mode == cbf_pkg::MODE_OPEN &&
                        cbf_pkg::t_time'(at_ms - opened_at) >= cfg_timeout) begin
                        mode     = cbf_pkg::MODE_HALF;
                        gen      = gen + cbf_pkg::t_permit'(1);
                        probes   = '0;
                        probe_ok = '0;
                    end
                    if (mode == cbf_pkg::MODE_HALF && probes < limit) begin
                        probes      = count_up(probes);
                        res.granted = 1'b1;
                        res.permit  = gen;
                    end
                end
            end
            cbf_pkg::ACT_OK: begin
                if (permit_in == gen) begin
                    res.applied = 1'b1;
                    if (mode == cbf_pkg::MODE_CLOSED) begin
                        if (!fail_seen || cbf_pkg::t_time'(at_ms - last_fail) >= window)
                            fail_cnt = '0;
                    end else if (mode == cbf_pkg::MODE_HALF) begin
                        probe_ok = count_up(probe_ok);
                        if (probe_ok >= need && probe_ok == probes) begin
                            mode      = cbf_pkg::MODE_CLOSED;
                            gen       = gen + cbf_pkg::t_permit'(1);
                            fail_cnt  = '0;
                            last_fail = '0;
                            fail_seen = 1'b0;
                            opened_at = '0;
                            probes    = '0;
                            probe_ok  = '0;
                        end
                    end
                end
            end
            cbf_pkg::ACT_FAIL: begin
                if (permit_in == gen) begin
                    res.applied = 1'b1;
                    if (mode == cbf_pkg::MODE_HALF) begin
                        trip_open(at_ms);
                    end else if (mode == cbf_pkg::MODE_CLOSED) begin
                        if (fail_seen && cbf_pkg::t_time'(at_ms - last_fail) >= window)
                            fail_cnt = '0;
                        last_fail = at_ms;
                        fail_seen = 1'b1;
                        fail_cnt  = count_up(fail_cnt);
                        if (fail_cnt >= thresh)
                            trip_open(at_ms);
                    end
                end
            end
            default: ;
        endcase
        res.mode = mode;
    endtask

    task automatic check_field(input string name, input cbf_pkg::t_permit want,
                               input cbf_pkg::t_permit got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        cbf_pkg::t_result want;
        if (!i_rst_n) begin
            clear_breaker();
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cbf_pkg::REG_THRESH:  cfg_thresh  = i_cfg_data[cbf_pkg::COUNT_W-1:0];
                    cbf_pkg::REG_WINDOW:  cfg_window  = i_cfg_data[cbf_pkg::TIME_W-1:0];
                    cbf_pkg::REG_TIMEOUT: cfg_timeout = i_cfg_data[cbf_pkg::TIME_W-1:0];
                    cbf_pkg::REG_LIMIT:   cfg_limit   = i_cfg_data[cbf_pkg::COUNT_W-1:0];
                    cbf_pkg::REG_NEED:    cfg_need    = i_cfg_data[cbf_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
            // results leave first so an unexpected one is never hidden by a new entry
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: result item with none expected, expected nothing, actual %h",
                             $time, i_m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    check_field("granted", cbf_pkg::t_permit'(want.granted),
                                cbf_pkg::t_permit'(i_m_tdata[0]));
                    check_field("permit_out", want.permit,
                                i_m_tdata[cbf_pkg::PERMIT_W:1]);
                    check_field("report_applied", cbf_pkg::t_permit'(want.applied),
                                cbf_pkg::t_permit'(i_m_tdata[cbf_pkg::PERMIT_W+1]));
                    check_field("breaker_mode", cbf_pkg::t_permit'(want.mode),
                                cbf_pkg::t_permit'(
                                    i_m_tdata[cbf_pkg::PERMIT_W+3:cbf_pkg::PERMIT_W+2]));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                breaker_step(cbf_pkg::t_action'(i_s_tuser[cbf_pkg::ACT_W-1:0]),
                             i_s_tdata[cbf_pkg::TIME_W-1:0],
                             i_s_tdata[cbf_pkg::TIME_W +: cbf_pkg::PERMIT_W], want);
                expected_results.push_back(want);
            end
        end
        o_errors   <= errors;
        o_waiting  <= expected_results.size();
        o_gen_hint <= gen;
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// top of the circuit breaker test: directed cases, then random phases over several
// register settings; depends on cbf_pkg, cbf_checker and circuit_breaker_fsm
module testbench;

    // action code the block must ignore
    localparam cbf_pkg::t_action ACT_UNUSED = 2'd3;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [cbf_pkg::IDX_W-1:0]      cfg_idx;
    logic [cbf_pkg::CFG_W-1:0]      cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [cbf_pkg::IN_DATA_W-1:0]  s_tdata;     // now_ms, permit_in
    logic [cbf_pkg::IN_USER_W-1:0]  s_tuser;     // action, zero fill
    logic                           m_tvalid;
    logic                           m_tready;
    logic [cbf_pkg::OUT_DATA_W-1:0] m_tdata;     // granted, permit_out, report_applied,
                                                 // breaker_mode

    int               errors;
    int               waiting;
    cbf_pkg::t_permit gen_hint;

    // stimulus bookkeeping
    logic            calm = 1'b0;       // no idling on either side while set
    cbf_pkg::t_time  cur_ms = '0;
    cbf_pkg::t_time  phase_timeout = cbf_pkg::RST_TIMEOUT;
    longint unsigned scale = 64'd60000;
    int              items_sent = 0;
    int              phases_run = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    circuit_breaker_fsm i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    cbf_checker i_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .o_errors   (errors),
        .o_waiting  (waiting),
        .o_gen_hint (gen_hint)
    );

    // receiver stalls with about 11 percent chance, never while calm is set
    always @(posedge clk)
        m_tready <= calm || ($urandom_range(99) >= 11);

    // one item; the sender may idle first, valid stays high between back-to-back items
    task automatic send_item(input cbf_pkg::t_action act, input cbf_pkg::t_time at_ms,
                             input cbf_pkg::t_permit permit);
        if (!calm)
            while ($urandom_range(99) < 11) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= {permit, at_ms};
        s_tuser  <= {{(cbf_pkg::IN_USER_W - cbf_pkg::ACT_W){1'b0}}, act};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // stop sending and wait until every result item is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [cbf_pkg::IDX_W-1:0] idx,
                             input logic [cbf_pkg::CFG_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [15:0] thresh, input logic [31:0] window,
                                 input logic [31:0] timeout, input logic [15:0] limit,
                                 input logic [15:0] need);
        write_reg(cbf_pkg::REG_THRESH, cbf_pkg::CFG_W'(thresh));
        write_reg(cbf_pkg::REG_WINDOW, cbf_pkg::CFG_W'(window));
        write_reg(cbf_pkg::REG_TIMEOUT, cbf_pkg::CFG_W'(timeout));
        write_reg(cbf_pkg::REG_LIMIT, cbf_pkg::CFG_W'(limit));
        write_reg(cbf_pkg::REG_NEED, cbf_pkg::CFG_W'(need));
        cfg_we <= 1'b0;
        @(posedge clk);
        phase_timeout = timeout;
        // time steps are sized from the slower of the two windows
        scale = (window > timeout) ? window : timeout;
        if (scale < 8)
            scale = 8;
        phases_run++;
    endtask

    // move the clock forward by up to upper ms
    task automatic advance(input longint unsigned upper);
        if (upper > 64'hFFFF_FFFF)
            upper = 64'hFFFF_FFFF;
        cur_ms = cur_ms + cbf_pkg::t_time'($urandom_range(32'(upper), 0));
    endtask

    // mix of no step, short steps, steps past the windows and arbitrary jumps (wrap)
    task automatic wander();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            ;
        else if (r < 65)
            advance(scale / 4);
        else if (r < 90) begin
            cur_ms = cur_ms + cbf_pkg::t_time'(scale / 2);
            advance(scale);
        end else
            cur_ms = cur_ms + cbf_pkg::t_time'($urandom());
    endtask

    // mostly the current generation, sometimes a neighbor or junk
    function automatic cbf_pkg::t_permit pick_permit();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return gen_hint;
        else if (r < 90)
            return gen_hint + cbf_pkg::t_permit'(1);
        else if (r < 95)
            return gen_hint - cbf_pkg::t_permit'(1);
        return cbf_pkg::t_permit'($urandom());
    endfunction

    function automatic cbf_pkg::t_action pick_action();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return cbf_pkg::ACT_REQ;
        else if (r < 68)
            return cbf_pkg::ACT_OK;
        else if (r < 95)
            return cbf_pkg::ACT_FAIL;
        return ACT_UNUSED;
    endfunction

    // random traffic: loose items, failure bursts that trip the breaker, and probe
    // rounds after the recovery timeout
    task automatic run_phase(input int count);
        int start;
        int r;
        int n;
        int k;
        start = items_sent;
        while (items_sent - start < count) begin
            r = $urandom_range(99);
            if (r < 55) begin
                wander();
                send_item(pick_action(), cur_ms, pick_permit());
            end else if (r < 75) begin
                n = $urandom_range(6, 1);
                for (k = 0; k < n; k++) begin
                    advance(scale / 3);
                    send_item(cbf_pkg::ACT_FAIL, cur_ms, pick_permit());
                end
            end else begin
                cur_ms = cur_ms + phase_timeout;
                advance(scale / 4);
                n = $urandom_range(4, 1);
                for (k = 0; k < n; k++) begin
                    advance(2);
                    send_item(cbf_pkg::ACT_REQ, cur_ms, pick_permit());
                end
                n = $urandom_range(4, 1);
                for (k = 0; k < n; k++) begin
                    advance(scale / 8);
                    send_item(($urandom_range(3) == 0) ? cbf_pkg::ACT_FAIL : cbf_pkg::ACT_OK,
                              cur_ms, pick_permit());
                end
            end
        end
    endtask

    initial begin
        rst_n    <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_idx  <= '0;
        cfg_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        m_tready <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on reset settings: 5 / 60000 / 30000 / 1 / 1
        send_item(cbf_pkg::ACT_REQ, 32'd0, 32'd0);          // closed grant, permit 0
        send_item(ACT_UNUSED, 32'd0, 32'd0);                // ignored code
        send_item(cbf_pkg::ACT_OK, 32'd10, 32'd0);          // success, no failure recorded
        send_item(cbf_pkg::ACT_OK, 32'd20, 32'd5);          // stale permit
        send_item(cbf_pkg::ACT_FAIL, 32'd100, 32'd0);
        send_item(cbf_pkg::ACT_FAIL, 32'd200, 32'd0);
        send_item(cbf_pkg::ACT_FAIL, 32'd300, 32'd0);
        send_item(cbf_pkg::ACT_FAIL, 32'd400, 32'd0);
        send_item(cbf_pkg::ACT_FAIL, 32'd500, 32'd0);       // threshold reached, opens
        send_item(cbf_pkg::ACT_FAIL, 32'd600, 32'd1);       // matching report while open
        send_item(cbf_pkg::ACT_OK, 32'd700, 32'd1);
        send_item(cbf_pkg::ACT_REQ, 32'd1000, 32'd0);       // refused, still open
        send_item(cbf_pkg::ACT_REQ, 32'd30500, 32'd0);      // exactly the timeout: probe
        send_item(cbf_pkg::ACT_REQ, 32'd30501, 32'd0);      // probe limit used up
        send_item(cbf_pkg::ACT_FAIL, 32'd30600, 32'd2);     // half-open failure reopens
        send_item(cbf_pkg::ACT_REQ, 32'd60600, 32'd0);
        send_item(cbf_pkg::ACT_OK, 32'd60700, 32'd4);       // probe success closes
        send_item(cbf_pkg::ACT_FAIL, 32'hFFFF_FFF0, 32'd5);
        send_item(cbf_pkg::ACT_FAIL, 32'h0000_0010, 32'd5); // time wraps, inside window
        send_item(cbf_pkg::ACT_OK, 32'h0000_0020, 32'd5);   // recent failure keeps the count
        send_item(cbf_pkg::ACT_FAIL, 32'd60032, 32'd5);     // window expired, count restarts
        send_item(cbf_pkg::ACT_OK, 32'd120032, 32'd5);      // old failure, count cleared
        send_item(cbf_pkg::ACT_REQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // all ones everywhere
        send_item(cbf_pkg::ACT_FAIL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();
        cur_ms = 32'd120032;

        // lowest settings: every failure trips, no recovery wait
        load_settings(16'd1, 32'd1, 32'd0, 16'd1, 16'd1);
        run_phase(150);
        drain();

        // long run without idling on either side
        calm = 1'b1;
        load_settings(16'd3, 32'd100, 32'd40, 16'd3, 16'd2);
        run_phase(200);
        drain();
        calm = 1'b0;

        // success_needed above probe_limit, capped by it
        load_settings(16'd2, 32'd1000, 32'd300, 16'd4, 16'd9);
        run_phase(150);
        drain();

        // highest settings
        load_settings(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        run_phase(100);
        drain();

        load_settings(16'd4, 32'd200, 32'd0, 16'd2, 16'd2);
        run_phase(150);
        drain();

        repeat (5) begin
            load_settings(16'($urandom_range(6, 1)), $urandom_range(400, 1),
                          $urandom_range(300, 0), 16'($urandom_range(5, 1)),
                          16'($urandom_range(6, 1)));
            run_phase(150);
            drain();
        end

        // wait idle so the last counts reach the top
        repeat (4) @(posedge clk);
        $display("%0d items sent over %0d register settings plus reset values,", items_sent,
                 phases_run);
        $display("with trips, probe rounds, stale permits, time wrap and idle/stall gaps");
        if (errors == 0 && waiting == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #400000;
        $display("Verification failed");
        $finish;
    end

endmodule
